/* hdl/assert_macros.svh */
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define SHA_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/sha256_pkg.sv */
// Types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} req_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} res_t;

	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_ROUND,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		BYTE_DATA,
		BYTE_PAD,
		BYTE_ZERO,
		BYTE_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      shift_byte;
		byte_sel_t byte_sel;
		logic      count_byte;
		logic      latch_len;
		logic      start_comp;
		logic      do_round;
		logic      update_hash;
		logic      emit_word;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       round_last;
		logic       emit_last;
		logic       emit_free;
	} sts_t;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_FILL  = 6'd56;
	localparam logic [5:0] LAST_FILL = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [2:0] LAST_WORD = 3'd7;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

/* hdl/sha256_stream_hasher_core.sv */
// Top level of the SHA-256 stream hasher.
// Usage: each request on req carries kind and data_byte. kind 0 appends one
// message byte; kind 1 finishes the message and yields the digest as eight
// results on res, word 0 (most significant) first, last set on word 7.
// An append request is taken whenever req_ready is high, which is only in
// the idle state. The request that completes a 64-byte block starts one
// compression: 64 rounds, one per cycle, then an update step that folds
// the result into the hash; req_ready stays low until the update is done.
// A finish request inserts padding one byte per cycle outside compressions,
// with a step that shifts no byte before the eight length bytes, runs one
// compression when fewer than 56 bytes are pending and two otherwise, then
// loads one digest word per cycle into the output register as res_ready allows.
// Requests are not taken while a compression runs, so loading bytes and
// running rounds never overlap.
// A new request may be taken while the last digest word still waits on res.
// When the receiver holds res_ready low, the output register keeps its word
// and digest loading pauses.
// After reset the hash holds the standard initial values, the block is empty
// and the bit count is zero; the same holds after each digest.
module sha256_stream_hasher_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  sha256_pkg::req_t   req,
	output logic               res_valid,
	input  logic               res_ready,
	output sha256_pkg::res_t   res
);

	sha256_pkg::cmd_t cmd;
	sha256_pkg::sts_t sts;

	sha256_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_kind  (req.kind),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha256_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

/* hdl/sha256_ctrl.sv */
// Controller state machine of the SHA-256 stream hasher.
`include "assert_macros.svh"

module sha256_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               req_kind,
	input  sha256_pkg::sts_t   sts,
	output sha256_pkg::cmd_t   cmd
);

	sha256_pkg::state_t state_q, state_nxt;
	sha256_pkg::state_t ret_q, ret_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
			ret_q   <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
			if (cmd.start_comp) begin
				ret_q <= ret_nxt;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		ret_nxt   = ret_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_kind == sha256_pkg::KIND_APPEND) begin
						if (sts.fill == sha256_pkg::LAST_FILL) begin
							state_nxt = sha256_pkg::ST_ROUND;
							ret_nxt   = sha256_pkg::ST_IDLE;
						end
					end else begin
						state_nxt = sha256_pkg::ST_PAD80;
					end
				end
			end
			sha256_pkg::ST_PAD80: begin
				state_nxt = sha256_pkg::ST_PADZ;
				if (sts.fill == sha256_pkg::LAST_FILL) begin
					state_nxt = sha256_pkg::ST_ROUND;
					ret_nxt   = sha256_pkg::ST_PADZ;
				end
			end
			sha256_pkg::ST_PADZ: begin
				if (sts.fill == sha256_pkg::LEN_FILL) begin
					state_nxt = sha256_pkg::ST_PADLEN;
				end else if (sts.fill == sha256_pkg::LAST_FILL) begin
					state_nxt = sha256_pkg::ST_ROUND;
					ret_nxt   = sha256_pkg::ST_PADZ;
				end
			end
			sha256_pkg::ST_PADLEN: begin
				if (sts.fill == sha256_pkg::LAST_FILL) begin
					state_nxt = sha256_pkg::ST_ROUND;
					ret_nxt   = sha256_pkg::ST_EMIT;
				end
			end
			sha256_pkg::ST_ROUND: begin
				if (sts.round_last) begin
					state_nxt = sha256_pkg::ST_UPDATE;
				end
			end
			sha256_pkg::ST_UPDATE: begin
				state_nxt = ret_q;
			end
			sha256_pkg::ST_EMIT: begin
				if (sts.emit_free && sts.emit_last) begin
					state_nxt = sha256_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = '0;
		cmd.byte_sel = sha256_pkg::BYTE_DATA;
		unique case (state_q)
			sha256_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_kind == sha256_pkg::KIND_APPEND) begin
						cmd.shift_byte = 1'b1;
						cmd.count_byte = 1'b1;
						cmd.start_comp = (sts.fill == sha256_pkg::LAST_FILL);
					end else begin
						cmd.latch_len = 1'b1;
					end
				end
			end
			sha256_pkg::ST_PAD80: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_sel   = sha256_pkg::BYTE_PAD;
				cmd.start_comp = (sts.fill == sha256_pkg::LAST_FILL);
			end
			sha256_pkg::ST_PADZ: begin
				if (sts.fill != sha256_pkg::LEN_FILL) begin
					cmd.shift_byte = 1'b1;
					cmd.byte_sel   = sha256_pkg::BYTE_ZERO;
					cmd.start_comp = (sts.fill == sha256_pkg::LAST_FILL);
				end
			end
			sha256_pkg::ST_PADLEN: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_sel   = sha256_pkg::BYTE_LEN;
				cmd.start_comp = (sts.fill == sha256_pkg::LAST_FILL);
			end
			sha256_pkg::ST_ROUND: begin
				cmd.do_round = 1'b1;
			end
			sha256_pkg::ST_UPDATE: begin
				cmd.update_hash = 1'b1;
			end
			sha256_pkg::ST_EMIT: begin
				cmd.emit_word = sts.emit_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// The length bytes always end a block, so the last one starts a compression.
	`SHA_ASSERT_NEXT(a_len_starts_comp, clk, arst_n,
		(state_q == sha256_pkg::ST_PADLEN && sts.fill == sha256_pkg::LAST_FILL),
		(state_q == sha256_pkg::ST_ROUND), "length byte did not start compression")
	`SHA_ASSERT_NEXT(a_round_to_update, clk, arst_n,
		(state_q == sha256_pkg::ST_ROUND && sts.round_last),
		(state_q == sha256_pkg::ST_UPDATE), "last round not followed by update")
	`SHA_ASSERT_ALWAYS(a_ready_idle, clk, arst_n,
		(!req_ready || state_q == sha256_pkg::ST_IDLE), "request taken outside idle")

endmodule

/* hdl/sha256_dp.sv */
// Datapath of the SHA-256 stream hasher: block shifter, rounds, hash and result.
`include "assert_macros.svh"

module sha256_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  sha256_pkg::cmd_t   cmd,
	output sha256_pkg::sts_t   sts,
	output logic               res_valid,
	input  logic               res_ready,
	output sha256_pkg::res_t   res
);

	logic [511:0]      blk_q;
	logic [7:0][31:0]  var_q;
	logic [7:0][31:0]  hash_q;
	logic [63:0]       bits_q;
	logic [63:0]       len_q;
	logic [5:0]        fill_q;
	logic [5:0]        round_q;
	logic [2:0]        idx_q;
	logic              res_valid_q;
	sha256_pkg::res_t  res_q;

	logic [7:0]  byte_in;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] t1, t2, ch, maj;

	always_comb begin
		case (cmd.byte_sel)
			sha256_pkg::BYTE_DATA: byte_in = data_byte;
			sha256_pkg::BYTE_PAD:  byte_in = sha256_pkg::PAD_BYTE;
			sha256_pkg::BYTE_LEN:  byte_in = len_q[63:56];
			default:               byte_in = 8'h00;
		endcase
	end

	// The block register doubles as the 16-word message schedule window.
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign w_new = sha256_pkg::small_sigma1(w14) + w9 + sha256_pkg::small_sigma0(w1) + w0;

	// var_q[7] is a, var_q[0] is h.
	assign ch  = (var_q[3] & var_q[2]) ^ (~var_q[3] & var_q[1]);
	assign maj = (var_q[7] & var_q[6]) ^ (var_q[7] & var_q[5]) ^ (var_q[6] & var_q[5]);
	assign t1  = var_q[0] + sha256_pkg::big_sigma1(var_q[3]) + ch +
		sha256_pkg::ROUND_K[round_q] + w0;
	assign t2  = sha256_pkg::big_sigma0(var_q[7]) + maj;

	always_ff @(posedge clk) begin
		if (cmd.shift_byte) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.do_round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.latch_len) begin
			len_q <= bits_q;
		end else if (cmd.shift_byte && cmd.byte_sel == sha256_pkg::BYTE_LEN) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (cmd.start_comp) begin
			for (int i = 0; i < 8; i++) begin
				var_q[7 - i] <= hash_q[7 - i];
			end
		end else if (cmd.do_round) begin
			var_q <= {t1 + t2, var_q[7:5], var_q[4] + t1, var_q[3:1]};
		end
		if (cmd.emit_word) begin
			res_q.digest_word <= hash_q[3'(sha256_pkg::LAST_WORD - idx_q)];
			res_q.word_index  <= idx_q;
			res_q.last        <= (idx_q == sha256_pkg::LAST_WORD);
		end
	end

	// hash_q[7] holds the first digest word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[7 - i] <= sha256_pkg::INIT_HASH[i];
			end
			bits_q      <= '0;
			fill_q      <= '0;
			round_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.shift_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.latch_len) begin
				bits_q <= '0;
			end else if (cmd.count_byte) begin
				bits_q <= bits_q + 64'd8;
			end
			if (cmd.start_comp) begin
				round_q <= '0;
			end else if (cmd.do_round) begin
				round_q <= round_q + 6'd1;
			end
			if (cmd.update_hash) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + var_q[i];
				end
			end else if (cmd.emit_word && idx_q == sha256_pkg::LAST_WORD) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[7 - i] <= sha256_pkg::INIT_HASH[i];
				end
			end
			if (cmd.emit_word) begin
				idx_q       <= idx_q + 3'd1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign sts.fill       = fill_q;
	assign sts.round_last = (round_q == sha256_pkg::LAST_ROUND);
	assign sts.emit_last  = (idx_q == sha256_pkg::LAST_WORD);
	assign sts.emit_free  = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// After the final digest word the chaining value is back at the initial hash.
	`SHA_ASSERT_NEXT(a_hash_reinit, clk, arst_n,
		(cmd.emit_word && idx_q == sha256_pkg::LAST_WORD),
		(hash_q[7] == sha256_pkg::INIT_HASH[0] && idx_q == 3'd0),
		"hash not reinitialized after digest")
	`SHA_ASSERT_ALWAYS(a_emit_block_full, clk, arst_n,
		(!cmd.emit_word || fill_q == 6'd0), "digest emitted with partial block")
	`SHA_ASSERT_NEXT(a_res_hold, clk, arst_n,
		(res_valid_q && !res_ready),
		(res_valid_q && $stable(res_q)), "result changed while stalled")

endmodule
